### sv/itoa_pkg.sv
`default_nettype none
package itoa_pkg;

  localparam int DATA_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 10;
  localparam int BIT_CNT_W  = $clog2(DATA_W);
  localparam int POS_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  // controls broadcast to every digit cell
  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // add-3 adjust, then shift one binary bit in
    logic shift;  // move whole digit up to the next cell
  } cell_ctrl_t;

endpackage
`default_nettype wire

### sv/itoa_cell.sv
`default_nettype none
// One BCD digit of the double-dabble chain.
module itoa_cell (
  input  wire                               clk,
  input  itoa_pkg::cell_ctrl_t              ctrl,
  input  wire                               bit_in,
  output logic                              bit_out,
  input  wire  [itoa_pkg::DIGIT_W-1:0]      digit_in,
  output logic [itoa_pkg::DIGIT_W-1:0]      digit_out
);

  logic [itoa_pkg::DIGIT_W-1:0] digit;
  logic [itoa_pkg::DIGIT_W-1:0] adj;

  assign adj       = (digit >= itoa_pkg::ADJ_LIMIT) ? digit + itoa_pkg::ADJ_ADD : digit;
  assign bit_out   = adj[itoa_pkg::DIGIT_W-1];
  assign digit_out = digit;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= {adj[itoa_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule
`default_nettype wire

### sv/signed_int_to_decimal_ascii.sv
`default_nettype none
// Signed 32-bit integer to decimal ASCII. Pulse start while busy is low to
// hand in one value; the block then sends its text out one character per
// strobe, most significant first, with is_last on the final character.
// The receiver cannot stall: each character is marked by strobe for one
// cycle only and must be taken then. A negative value's '-' comes out in the
// cycle right after acceptance. The digits come out at the end of the run,
// back to back, and the last digit shows in the same cycle that busy drops.
// Busy stays high for each item through 32 double-dabble shifts through a
// row of ten BCD digit cells, then 10 digit positions shifted up the row
// (leading zeros dropped), so no new value is taken until the last digit
// of the previous one goes out.
module signed_int_to_decimal_ascii (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  output logic                                busy,
  input  wire  signed [itoa_pkg::DATA_W-1:0]  value,
  output logic                                strobe,
  output logic [itoa_pkg::CHAR_W-1:0]         character,
  output logic                                is_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_DIGS = 2'd2;

  localparam logic [itoa_pkg::BIT_CNT_W-1:0] BIT_LAST =
    itoa_pkg::BIT_CNT_W'(itoa_pkg::DATA_W - 1);
  localparam logic [itoa_pkg::POS_W-1:0] POS_LAST =
    itoa_pkg::POS_W'(itoa_pkg::NUM_DIGITS - 1);

  logic [1:0]                       state;
  logic [itoa_pkg::DATA_W-1:0]      mag;      // binary shift register, msb first
  logic [itoa_pkg::BIT_CNT_W-1:0]   bit_cnt;
  logic [itoa_pkg::POS_W-1:0]       pos;
  logic                             seen;     // a nonzero digit went out already

  logic                             accept;
  logic [itoa_pkg::DATA_W-1:0]      value_u;
  itoa_pkg::cell_ctrl_t             ctrl;
  logic                             emit;

  // chain links: index 0 is the least significant digit
  logic [itoa_pkg::NUM_DIGITS:0]    bit_link;
  logic [itoa_pkg::DIGIT_W-1:0]     dig_link [itoa_pkg::NUM_DIGITS+1];

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign value_u = value;

  assign ctrl.clear = accept;
  assign ctrl.conv  = (state == ST_CONV);
  assign ctrl.shift = (state == ST_DIGS);

  assign bit_link[0] = mag[itoa_pkg::DATA_W-1];
  assign dig_link[0] = '0;

  genvar g;
  generate
    for (g = 0; g < itoa_pkg::NUM_DIGITS; g++) begin : g_cell
      itoa_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (bit_link[g]),
        .bit_out   (bit_link[g+1]),
        .digit_in  (dig_link[g]),
        .digit_out (dig_link[g+1])
      );
    end
  endgenerate

  // top cell holds the digit under emission; the final position always goes out
  assign emit = (state == ST_DIGS) &&
                (seen || (dig_link[itoa_pkg::NUM_DIGITS] != '0) || (pos == POS_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      strobe  <= 1'b0;
      bit_cnt <= '0;
      pos     <= '0;
      seen    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state   <= ST_CONV;
            bit_cnt <= '0;
            pos     <= '0;
            seen    <= 1'b0;
            strobe  <= value_u[itoa_pkg::DATA_W-1];
          end
        end
        ST_CONV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_LAST) begin
            state <= ST_DIGS;
          end
        end
        ST_DIGS: begin
          pos    <= pos + 1'b1;
          strobe <= emit;
          if (emit) begin
            seen <= 1'b1;
          end
          if (pos == POS_LAST) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload: magnitude register and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= value_u[itoa_pkg::DATA_W-1] ? (itoa_pkg::DATA_W'(0) - value_u) : value_u;
    end else if (state == ST_CONV) begin
      mag <= {mag[itoa_pkg::DATA_W-2:0], 1'b0};
    end

    if (accept) begin
      character <= itoa_pkg::CHAR_MINUS;
      is_last   <= 1'b0;
    end else if (state == ST_DIGS) begin
      character <= itoa_pkg::CHAR_ZERO
                 | itoa_pkg::CHAR_W'(dig_link[itoa_pkg::NUM_DIGITS]);
      is_last   <= (pos == POS_LAST);
    end
  end

endmodule
`default_nettype wire

### sv/itoa_checker.sv
`default_nettype none
module itoa_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               start,
  input wire                               busy,
  input wire                               strobe,
  input wire [itoa_pkg::CHAR_W-1:0]        character,
  input wire                               is_last
);

  // accepted word starts a run
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // digits of one run go out back to back
  a_digits_contig: assert property (@(posedge clk) disable iff (rst)
    (strobe && !is_last && (character != itoa_pkg::CHAR_MINUS)) |=> strobe)
    else $error("gap inside digit run");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((character == itoa_pkg::CHAR_MINUS) ||
                ((character >= itoa_pkg::CHAR_ZERO) &&
                 (character <= itoa_pkg::CHAR_ZERO + 8'd9))))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (character == itoa_pkg::CHAR_MINUS)) |-> !is_last)
    else $error("sign marked last");

  // only the '-' of the next word may follow the last character directly
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |=> (!strobe || (character == itoa_pkg::CHAR_MINUS)))
    else $error("digit right after last character");

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .is_last   (is_last)
);
`default_nettype wire
